FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file tdc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("time_of_day_clock: assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("time_of_day_clock: assertion failed");

`endif

FILE: hdl/tdc_pkg.sv
// ----------------------------------------------------------------------------
// tdc_pkg
// Shared types, command codes and helpers for the time-of-day clock.
// ----------------------------------------------------------------------------
`default_nettype none

package tdc_pkg;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_RESET = 2'd1;
  localparam logic [1:0] KIND_SET   = 2'd2;
  localparam logic [1:0] KIND_STOP  = 2'd3;

  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] ASCII_NINE = 8'd57;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] hour_tens_char;
    logic [7:0] hour_ones_char;
    logic [7:0] minute_tens_char;
    logic [7:0] minute_ones_char;
    logic [7:0] second_tens_char;
    logic [7:0] second_ones_char;
  } req_t;

  // Time of day held as BCD digits.
  typedef struct packed {
    logic [1:0] hour_tens;
    logic [3:0] hour_ones;
    logic [2:0] minute_tens;
    logic [3:0] minute_ones;
    logic [2:0] second_tens;
    logic [3:0] second_ones;
  } bcd_time_t;

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= ASCII_ZERO) && (c <= ASCII_NINE);
  endfunction

  // '0'..'9' is 6'b11_0000 plus the digit.
  function automatic logic [5:0] to_ascii(input logic [3:0] d);
    to_ascii = {2'b11, d};
  endfunction

endpackage

`default_nettype wire

FILE: hdl/tdc_req_stage.sv
// ----------------------------------------------------------------------------
// tdc_req_stage
// Input register: captures one request per cycle and holds it while stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module tdc_req_stage (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire tdc_pkg::req_t in_req,
  input  wire                advance,
  output logic               req_valid,
  output tdc_pkg::req_t      req
);

  logic          valid_r, valid_nxt;
  tdc_pkg::req_t req_r;

  assign in_stall  = valid_r && !advance;
  assign req_valid = valid_r;
  assign req       = req_r;

  always_comb begin
    valid_nxt = valid_r;
    if (!in_stall) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_r <= in_req;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tdc_time_core.sv
// ----------------------------------------------------------------------------
// tdc_time_core
// Time-of-day state in BCD, running flag, and the per-request update.
// ----------------------------------------------------------------------------
`default_nettype none

module tdc_time_core (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                fire,
  input  wire tdc_pkg::req_t req,
  output logic               res_valid,
  output tdc_pkg::bcd_time_t res_time
);

  tdc_pkg::bcd_time_t time_r, time_nxt, time_inc, time_set;
  logic               running_r, running_nxt;
  logic               chars_ok, range_ok;

  // BCD increment with wrap at 23:59:59.
  always_comb begin
    time_inc = time_r;
    if (time_r.second_ones != 4'd9) begin
      time_inc.second_ones = time_r.second_ones + 4'd1;
    end else begin
      time_inc.second_ones = 4'd0;
      if (time_r.second_tens != 3'd5) begin
        time_inc.second_tens = time_r.second_tens + 3'd1;
      end else begin
        time_inc.second_tens = 3'd0;
        if (time_r.minute_ones != 4'd9) begin
          time_inc.minute_ones = time_r.minute_ones + 4'd1;
        end else begin
          time_inc.minute_ones = 4'd0;
          if (time_r.minute_tens != 3'd5) begin
            time_inc.minute_tens = time_r.minute_tens + 3'd1;
          end else begin
            time_inc.minute_tens = 3'd0;
            if (time_r.hour_tens == 2'd2 && time_r.hour_ones == 4'd3) begin
              time_inc.hour_tens = 2'd0;
              time_inc.hour_ones = 4'd0;
            end else if (time_r.hour_ones == 4'd9) begin
              time_inc.hour_ones = 4'd0;
              time_inc.hour_tens = time_r.hour_tens + 2'd1;
            end else begin
              time_inc.hour_ones = time_r.hour_ones + 4'd1;
            end
          end
        end
      end
    end
  end

  // Set request: low nibble of an ASCII digit is its value.
  always_comb begin
    chars_ok = tdc_pkg::is_digit(req.hour_tens_char)
            && tdc_pkg::is_digit(req.hour_ones_char)
            && tdc_pkg::is_digit(req.minute_tens_char)
            && tdc_pkg::is_digit(req.minute_ones_char)
            && tdc_pkg::is_digit(req.second_tens_char)
            && tdc_pkg::is_digit(req.second_ones_char);
    range_ok = ((req.hour_tens_char[3:0] < 4'd2)
             || (req.hour_tens_char[3:0] == 4'd2 && req.hour_ones_char[3:0] <= 4'd3))
            && (req.minute_tens_char[3:0] <= 4'd5)
            && (req.second_tens_char[3:0] <= 4'd5);
    time_set.hour_tens   = req.hour_tens_char[1:0];
    time_set.hour_ones   = req.hour_ones_char[3:0];
    time_set.minute_tens = req.minute_tens_char[2:0];
    time_set.minute_ones = req.minute_ones_char[3:0];
    time_set.second_tens = req.second_tens_char[2:0];
    time_set.second_ones = req.second_ones_char[3:0];
  end

  always_comb begin
    time_nxt    = time_r;
    running_nxt = running_r;
    res_valid   = 1'b0;
    if (fire) begin
      case (req.kind)
        tdc_pkg::KIND_TICK: begin
          if (running_r) begin
            time_nxt  = time_inc;
            res_valid = 1'b1;
          end
        end
        tdc_pkg::KIND_RESET: begin
          time_nxt    = '0;
          running_nxt = 1'b1;
        end
        tdc_pkg::KIND_SET: begin
          if (chars_ok && range_ok) begin
            time_nxt    = time_set;
            running_nxt = 1'b1;
          end
        end
        tdc_pkg::KIND_STOP: begin
          running_nxt = 1'b0;
        end
        default: begin
          running_nxt = running_r;
        end
      endcase
    end
  end

  assign res_time = time_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r    <= '0;
      running_r <= 1'b0;
    end else begin
      time_r    <= time_nxt;
      running_r <= running_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tdc_out_stage.sv
// ----------------------------------------------------------------------------
// tdc_out_stage
// Result register: formats the new time as ASCII and holds it until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tdc_out_stage (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     res_valid,
  input  wire tdc_pkg::bcd_time_t res_time,
  output logic                    advance,
  output logic                    out_valid,
  input  wire                     out_stall,
  output logic [5:0]              out_shown_hour_tens,
  output logic [5:0]              out_shown_hour_ones,
  output logic [5:0]              out_shown_minute_tens,
  output logic [5:0]              out_shown_minute_ones,
  output logic [5:0]              out_shown_second_tens,
  output logic [5:0]              out_shown_second_ones
);

  logic       valid_r, valid_nxt;
  logic [5:0] ht_r, ho_r, mt_r, mo_r, st_r, so_r;

  // Advance whenever the result slot is empty or being taken.
  assign advance   = !valid_r || !out_stall;
  assign valid_nxt = advance ? res_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      ht_r <= tdc_pkg::to_ascii({2'b00, res_time.hour_tens});
      ho_r <= tdc_pkg::to_ascii(res_time.hour_ones);
      mt_r <= tdc_pkg::to_ascii({1'b0, res_time.minute_tens});
      mo_r <= tdc_pkg::to_ascii(res_time.minute_ones);
      st_r <= tdc_pkg::to_ascii({1'b0, res_time.second_tens});
      so_r <= tdc_pkg::to_ascii(res_time.second_ones);
    end
  end

  assign out_valid             = valid_r;
  assign out_shown_hour_tens   = ht_r;
  assign out_shown_hour_ones   = ho_r;
  assign out_shown_minute_tens = mt_r;
  assign out_shown_minute_ones = mo_r;
  assign out_shown_second_tens = st_r;
  assign out_shown_second_ones = so_r;

endmodule

`default_nettype wire

FILE: hdl/time_of_day_clock.sv
// A request waits in the request register; when it fires, the time register
// updates and a tick's result enters the result register in the same cycle.
// Throughput: one request per cycle unless a result held under out_stall
// stalls the input. Reset (rst_n low, synchronous) zeroes the time,
// stops the clock and empties both the request and the result register.
// ----------------------------------------------------------------------------
// time_of_day_clock
// HH:MM:SS clock driven by tick, reset, set and stop requests.
// ----------------------------------------------------------------------------
`default_nettype none

module time_of_day_clock (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire [1:0]  in_kind,
  input  wire [7:0]  in_hour_tens_char,
  input  wire [7:0]  in_hour_ones_char,
  input  wire [7:0]  in_minute_tens_char,
  input  wire [7:0]  in_minute_ones_char,
  input  wire [7:0]  in_second_tens_char,
  input  wire [7:0]  in_second_ones_char,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [5:0] out_shown_hour_tens,
  output logic [5:0] out_shown_hour_ones,
  output logic [5:0] out_shown_minute_tens,
  output logic [5:0] out_shown_minute_ones,
  output logic [5:0] out_shown_second_tens,
  output logic [5:0] out_shown_second_ones
);

  tdc_pkg::req_t      in_req, req;
  tdc_pkg::bcd_time_t res_time;
  logic               req_valid, advance, res_valid;

  assign in_req.kind             = in_kind;
  assign in_req.hour_tens_char   = in_hour_tens_char;
  assign in_req.hour_ones_char   = in_hour_ones_char;
  assign in_req.minute_tens_char = in_minute_tens_char;
  assign in_req.minute_ones_char = in_minute_ones_char;
  assign in_req.second_tens_char = in_second_tens_char;
  assign in_req.second_ones_char = in_second_ones_char;

  tdc_req_stage u_req (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .advance   (advance),
    .req_valid (req_valid),
    .req       (req)
  );

  tdc_time_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (req_valid && advance),
    .req       (req),
    .res_valid (res_valid),
    .res_time  (res_time)
  );

  tdc_out_stage u_out (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .res_valid             (res_valid),
    .res_time              (res_time),
    .advance               (advance),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_shown_hour_tens   (out_shown_hour_tens),
    .out_shown_hour_ones   (out_shown_hour_ones),
    .out_shown_minute_tens (out_shown_minute_tens),
    .out_shown_minute_ones (out_shown_minute_ones),
    .out_shown_second_tens (out_shown_second_tens),
    .out_shown_second_ones (out_shown_second_ones)
  );

endmodule

`default_nettype wire

FILE: hdl/tdc_checker.sv
// ----------------------------------------------------------------------------
// tdc_checker
// Port-level checks on the time-of-day clock, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tdc_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_stall,
  input wire [1:0] in_kind,
  input wire [7:0] in_hour_tens_char,
  input wire [7:0] in_hour_ones_char,
  input wire [7:0] in_minute_tens_char,
  input wire [7:0] in_minute_ones_char,
  input wire [7:0] in_second_tens_char,
  input wire [7:0] in_second_ones_char,
  input wire       out_valid,
  input wire       out_stall,
  input wire [5:0] out_shown_hour_tens,
  input wire [5:0] out_shown_hour_ones,
  input wire [5:0] out_shown_minute_tens,
  input wire [5:0] out_shown_minute_ones,
  input wire [5:0] out_shown_second_tens,
  input wire [5:0] out_shown_second_ones
);

  logic [49:0] in_fields;
  logic [35:0] out_fields;
  logic        hour_ok, sixty_ok;

  assign in_fields  = {in_kind, in_hour_tens_char, in_hour_ones_char,
                       in_minute_tens_char, in_minute_ones_char,
                       in_second_tens_char, in_second_ones_char};
  assign out_fields = {out_shown_hour_tens, out_shown_hour_ones,
                       out_shown_minute_tens, out_shown_minute_ones,
                       out_shown_second_tens, out_shown_second_ones};

  // Hours never go past 23 and minute/second tens never past 5.
  assign hour_ok  = (out_shown_hour_tens < 6'd50)
                 || (out_shown_hour_tens == 6'd50 && out_shown_hour_ones <= 6'd51);
  assign sixty_ok = out_shown_minute_tens >= 6'd48 && out_shown_minute_tens <= 6'd53
                 && out_shown_second_tens >= 6'd48 && out_shown_second_tens <= 6'd53;

  `ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid && $stable(in_fields))
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_fields))
  `ASSERT_IMPL(a_hour_range, clk, rst_n, out_valid, hour_ok)
  `ASSERT_IMPL(a_sixty_range, clk, rst_n, out_valid, sixty_ok)

endmodule

bind time_of_day_clock tdc_checker u_tdc_checker (.*);

`default_nettype wire

FILE: verif/time_of_day_checker.sv
// ----------------------------------------------------------------------------
// time_of_day_checker
// Watches the request and result channels of the time-of-day clock. It keeps
// its own copy of the seconds-of-day count and the running flag, queues the
// HH:MM:SS digits each accepted tick while running must show, and compares every
// accepted result, field by field, against the oldest time still due.
// ----------------------------------------------------------------------------
module time_of_day_checker
  import tdc_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  input  wire        in_stall,
  input  wire [1:0]  in_kind,
  input  wire [7:0]  in_hour_tens_char,
  input  wire [7:0]  in_hour_ones_char,
  input  wire [7:0]  in_minute_tens_char,
  input  wire [7:0]  in_minute_ones_char,
  input  wire [7:0]  in_second_tens_char,
  input  wire [7:0]  in_second_ones_char,
  input  wire        out_valid,
  input  wire        out_stall,
  input  wire [5:0]  out_shown_hour_tens,
  input  wire [5:0]  out_shown_hour_ones,
  input  wire [5:0]  out_shown_minute_tens,
  input  wire [5:0]  out_shown_minute_ones,
  input  wire [5:0]  out_shown_second_tens,
  input  wire [5:0]  out_shown_second_ones,
  output int         times_due,
  output int         mismatch_count
);

  localparam int DAY_SECONDS  = 86400;
  localparam int HOUR_LIMIT   = 23;
  localparam int MINUTE_LIMIT = 59;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [5:0] hour_tens;
    logic [5:0] hour_ones;
    logic [5:0] minute_tens;
    logic [5:0] minute_ones;
    logic [5:0] second_tens;
    logic [5:0] second_ones;
  } shown_time_t;

  logic [16:0] day_seconds;
  logic        clock_running;
  shown_time_t shown_due[$];

  initial begin
    times_due      = 0;
    mismatch_count = 0;
  end

  function automatic int digit_of(input logic [7:0] c);
    if (c < ASCII_ZERO || c > ASCII_NINE) return -1;
    return int'(c - ASCII_ZERO);
  endfunction

  // Seconds of day for a set request, or -1 when the request is dropped.
  function automatic int parse_set_time(input logic [47:0] chars);
    int d[6];
    int h, m, s;
    for (int i = 0; i < 6; i++) begin
      d[i] = digit_of(chars[47 - 8 * i -: 8]);
      if (d[i] < 0) return -1;
    end
    h = d[0] * 10 + d[1];
    m = d[2] * 10 + d[3];
    s = d[4] * 10 + d[5];
    if (h > HOUR_LIMIT || m > MINUTE_LIMIT || s > MINUTE_LIMIT) return -1;
    return h * 3600 + m * 60 + s;
  endfunction

  function automatic shown_time_t format_time(input logic [16:0] secs);
    int h, m, s;
    h = int'(secs) / 3600;
    m = (int'(secs) / 60) % 60;
    s = int'(secs) % 60;
    format_time.hour_tens   = 6'(ASCII_ZERO + h / 10);
    format_time.hour_ones   = 6'(ASCII_ZERO + h % 10);
    format_time.minute_tens = 6'(ASCII_ZERO + m / 10);
    format_time.minute_ones = 6'(ASCII_ZERO + m % 10);
    format_time.second_tens = 6'(ASCII_ZERO + s / 10);
    format_time.second_ones = 6'(ASCII_ZERO + s % 10);
  endfunction

  function automatic string time_text(input shown_time_t t);
    return $sformatf("%0d %0d : %0d %0d : %0d %0d", t.hour_tens, t.hour_ones,
                     t.minute_tens, t.minute_ones, t.second_tens, t.second_ones);
  endfunction

  task automatic report_mismatch(input string why, input string want_text,
                                 input shown_time_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%0t: %s: expected %s, got %s", $time, why, want_text,
               time_text(got));
  endtask

  always @(posedge clk) begin
    shown_time_t got, want;
    int          loaded;
    if (!rst_n) begin
      day_seconds   = '0;
      clock_running = 1'b0;
      shown_due.delete();
    end else begin
      // Results always leave later than their request, so check first.
      if (out_valid && !out_stall) begin
        got = {out_shown_hour_tens, out_shown_hour_ones, out_shown_minute_tens,
               out_shown_minute_ones, out_shown_second_tens,
               out_shown_second_ones};
        if (shown_due.size() == 0) begin
          report_mismatch("result with no time due", "nothing", got);
        end else begin
          want = shown_due.pop_front();
          if (got.hour_tens   !== want.hour_tens   ||
              got.hour_ones   !== want.hour_ones   ||
              got.minute_tens !== want.minute_tens ||
              got.minute_ones !== want.minute_ones ||
              got.second_tens !== want.second_tens ||
              got.second_ones !== want.second_ones)
            report_mismatch("shown time differs", time_text(want), got);
        end
      end
      if (in_valid && !in_stall) begin
        case (in_kind)
          KIND_TICK: begin
            if (clock_running) begin
              day_seconds = (day_seconds == 17'(DAY_SECONDS - 1)) ? '0
                                                                  : day_seconds + 1'b1;
              shown_due.push_back(format_time(day_seconds));
            end
          end
          KIND_RESET: begin
            day_seconds   = '0;
            clock_running = 1'b1;
          end
          KIND_SET: begin
            loaded = parse_set_time({in_hour_tens_char, in_hour_ones_char,
                                     in_minute_tens_char, in_minute_ones_char,
                                     in_second_tens_char, in_second_ones_char});
            if (loaded >= 0) begin
              day_seconds   = 17'(loaded);
              clock_running = 1'b1;
            end
          end
          KIND_STOP: clock_running = 1'b0;
        endcase
      end
    end
    times_due <= shown_due.size();
  end

endmodule

FILE: verif/tb_time_of_day_clock.sv
// ----------------------------------------------------------------------------
// tb_time_of_day_clock
// Drives tick, reset, set and stop requests into the time-of-day clock: a
// directed run over wrap-around, rejected set times and stopped ticks, then
// random requests in phases of sender gaps and result stalls. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_time_of_day_clock;
  import tdc_pkg::*;

  localparam int REQUESTS_PER_PHASE = 200;
  localparam int SETTLE_CYCLES      = 8;

  logic       clk;
  logic       rst_n               = 1'b0;
  logic       in_valid            = 1'b0;
  wire        in_stall;
  logic [1:0] in_kind             = KIND_TICK;
  logic [7:0] in_hour_tens_char   = '0;
  logic [7:0] in_hour_ones_char   = '0;
  logic [7:0] in_minute_tens_char = '0;
  logic [7:0] in_minute_ones_char = '0;
  logic [7:0] in_second_tens_char = '0;
  logic [7:0] in_second_ones_char = '0;
  wire        out_valid;
  logic       out_stall           = 1'b0;
  wire  [5:0] out_shown_hour_tens;
  wire  [5:0] out_shown_hour_ones;
  wire  [5:0] out_shown_minute_tens;
  wire  [5:0] out_shown_minute_ones;
  wire  [5:0] out_shown_second_tens;
  wire  [5:0] out_shown_second_ones;

  int times_due;
  int mismatch_count;
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  logic clock_on;  // whether ticks are expected to count, for pacing only

  time_of_day_clock dut (.*);
  time_of_day_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < receiver_stall_pct);

  function automatic logic [15:0] digit_pair(input int v);
    return {8'(ASCII_ZERO + v / 10), 8'(ASCII_ZERO + v % 10)};
  endfunction

  function automatic logic [47:0] clock_chars(input int h, input int m, input int s);
    return {digit_pair(h), digit_pair(m), digit_pair(s)};
  endfunction

  task automatic send_request(input logic [1:0] kind, input logic [47:0] chars);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    {in_hour_tens_char, in_hour_ones_char, in_minute_tens_char,
     in_minute_ones_char, in_second_tens_char, in_second_ones_char} <= chars;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold off new requests until every queued time has been shown.
  task automatic wait_all_shown();
    in_valid <= 1'b0;
    do @(posedge clk); while (times_due != 0);
  endtask

  task automatic run_directed();
    logic [47:0] chars;
    send_request(KIND_TICK, '1);                       // tick while stopped
    send_request(KIND_STOP, '0);                       // stop while stopped
    send_request(KIND_SET, clock_chars(23, 59, 58));   // set while stopped
    send_request(KIND_TICK, '0);
    send_request(KIND_TICK, '1);                       // wrap to midnight
    chars = clock_chars(12, 0, 0);
    chars[47:40] = 8'h2F;                              // just below '0'
    send_request(KIND_SET, chars);
    chars = clock_chars(12, 0, 0);
    chars[7:0] = 8'h3A;                                // just above '9'
    send_request(KIND_SET, chars);
    send_request(KIND_SET, clock_chars(24, 0, 0));
    send_request(KIND_SET, clock_chars(23, 60, 0));
    send_request(KIND_SET, clock_chars(0, 0, 60));
    send_request(KIND_TICK, '0);
    send_request(KIND_SET, clock_chars(9, 59, 59));    // set while running
    send_request(KIND_TICK, '0);
    send_request(KIND_SET, clock_chars(19, 59, 59));
    send_request(KIND_TICK, '0);
    send_request(KIND_RESET, '1);                      // reset while running
    send_request(KIND_TICK, '0);
    send_request(KIND_STOP, '1);
    send_request(KIND_TICK, '1);
    send_request(KIND_RESET, '0);
    send_request(KIND_TICK, '0);
    send_request(KIND_SET, clock_chars(0, 0, 0));
    send_request(KIND_TICK, '0);
    clock_on = 1'b1;
  endtask

  task automatic send_random_request(inout int counted);
    logic [47:0] noise, chars;
    logic [7:0]  bad;
    int          pick, h, m, s, pos;
    noise = 48'({$urandom, $urandom});
    pick  = $urandom_range(99);
    if (pick < 66) begin
      if (clock_on) counted++;
      send_request(KIND_TICK, noise);
    end else if (pick < 84) begin
      h = $urandom_range(23);
      m = $urandom_range(59);
      s = $urandom_range(59);
      // Lean toward times just short of a carry.
      if ($urandom_range(1)) begin
        s = $urandom_range(59, 55);
        if ($urandom_range(1)) m = 59;
        if ($urandom_range(3) == 0) h = 23;
      end
      chars = clock_chars(h, m, s);
      if ($urandom_range(99) < 35) begin
        case ($urandom_range(3))
          0: begin
            pos = $urandom_range(5);
            bad = 8'($urandom);
            if (bad >= ASCII_ZERO && bad <= ASCII_NINE) bad[7] = 1'b1;
            chars[8 * pos +: 8] = bad;
          end
          1: chars[47:32] = digit_pair($urandom_range(99, 24));
          2: chars[31:16] = digit_pair($urandom_range(99, 60));
          default: chars[15:0] = digit_pair($urandom_range(99, 60));
        endcase
      end else begin
        clock_on = 1'b1;
      end
      counted++;
      send_request(KIND_SET, chars);
    end else if (pick < 93) begin
      clock_on = 1'b1;
      counted++;
      send_request(KIND_RESET, noise);
    end else begin
      clock_on = 1'b0;
      counted++;
      send_request(KIND_STOP, noise);
    end
  endtask

  initial begin
    int idle_pcts[4];
    int stall_pcts[4];
    int counted;
    idle_pcts  = '{0, 70, 0, 7};
    stall_pcts = '{0, 0, 70, 7};
    clock_on   = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    wait_all_shown();
    for (int p = 0; p < 4; p++) begin
      sender_idle_pct    = idle_pcts[p];
      receiver_stall_pct = stall_pcts[p];
      counted = 0;
      while (counted < REQUESTS_PER_PHASE) send_random_request(counted);
      wait_all_shown();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && times_due == 0) begin
      $display("tb_time_of_day_clock OK");
    end else begin
      $display("tb_time_of_day_clock NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_time_of_day_clock NOT OK");
    $finish;
  end

endmodule
